>>> rtl/gbr_pkg.sv
// Shared types, constants and helpers for the 2bpp glyph run renderer.
package gbr_pkg;

    localparam int DIM_BITS     = 8;
    localparam int COLOR_BITS   = 16;
    localparam int RUN_BITS     = 16;
    localparam int BYTE_BITS    = 8;
    localparam int PIX_BITS     = 2;
    localparam int PIX_PER_BYTE = BYTE_BITS / PIX_BITS;
    localparam int K_BITS       = $clog2(PIX_PER_BYTE);
    localparam int PROD_BITS    = 2 * DIM_BITS;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_BACKGROUND  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_FULL  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_2THRD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_1THRD = 2'd3;

    localparam logic [PIX_BITS-1:0] LVL_FULL  = 2'd3;
    localparam logic [PIX_BITS-1:0] LVL_2THRD = 2'd2;
    localparam logic [PIX_BITS-1:0] LVL_1THRD = 2'd1;
    localparam logic [PIX_BITS-1:0] LVL_BG    = 2'd0;

    localparam logic [COLOR_BITS-1:0] FULL_COLOR_RESET = {COLOR_BITS{1'b1}};
    localparam logic [K_BITS-1:0]     K_LAST           = K_BITS'(PIX_PER_BYTE - 1);

    typedef enum logic [3:0] {
        CMD_DATA  = 4'b0001,
        CMD_GLYPH = 4'b0010,
        CMD_BLANK = 4'b0100,
        CMD_NONE  = 4'b1000
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [DIM_BITS-1:0]   iw;
        logic [DIM_BITS-1:0]   ih;
        logic [RUN_BITS-1:0]   lead;
        logic [RUN_BITS-1:0]   gap;
        logic [RUN_BITS-1:0]   trail;
        logic [BYTE_BITS-1:0]  pixels;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] background;
        logic [COLOR_BITS-1:0] full;
        logic [COLOR_BITS-1:0] two_thirds;
        logic [COLOR_BITS-1:0] one_third;
    } colors_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic [RUN_BITS-1:0]   length;
        logic                  last;
        logic                  done;
    } run_t;

    function automatic logic [COLOR_BITS-1:0] level_color(
        input logic [PIX_BITS-1:0] pix,
        input colors_t             colors
    );
        logic [COLOR_BITS-1:0] c;
        unique case (pix)
            LVL_FULL:  c = colors.full;
            LVL_2THRD: c = colors.two_thirds;
            LVL_1THRD: c = colors.one_third;
            LVL_BG:    c = colors.background;
            default:   c = colors.background;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/gbr_front.sv
// Front end: classify each input beat and precompute the run lengths of a header.
module gbr_front (
    input  logic                          op,
    input  logic [gbr_pkg::DIM_BITS-1:0]  glyph_width,
    input  logic [gbr_pkg::DIM_BITS-1:0]  glyph_height,
    input  logic [gbr_pkg::DIM_BITS-1:0]  top_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]  bottom_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]  left_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]  right_margin,
    input  logic [gbr_pkg::BYTE_BITS-1:0] bitmap_byte,
    output gbr_pkg::cmd_t                 cmd
);

    logic [gbr_pkg::DIM_BITS:0]    lr_sum;
    logic [gbr_pkg::DIM_BITS:0]    tb_sum;
    logic [gbr_pkg::PROD_BITS-1:0] top_prod;
    logic [gbr_pkg::PROD_BITS-1:0] bot_prod;
    logic [gbr_pkg::PROD_BITS-1:0] area_prod;
    logic [gbr_pkg::PROD_BITS:0]   lead_sum;
    logic [gbr_pkg::PROD_BITS:0]   trail_sum;
    logic                          zero_dim;
    logic                          no_interior;

    assign lr_sum    = {1'b0, left_margin} + {1'b0, right_margin};
    assign tb_sum    = {1'b0, top_margin} + {1'b0, bottom_margin};
    assign top_prod  = top_margin * glyph_width;
    assign bot_prod  = bottom_margin * glyph_width;
    assign area_prod = glyph_width * glyph_height;
    assign lead_sum  = {1'b0, top_prod} + (gbr_pkg::PROD_BITS + 1)'(left_margin);
    assign trail_sum = {1'b0, bot_prod} + (gbr_pkg::PROD_BITS + 1)'(right_margin);

    assign zero_dim    = (glyph_width == '0) || (glyph_height == '0);
    assign no_interior = (lr_sum >= {1'b0, glyph_width}) || (tb_sum >= {1'b0, glyph_height});

    always_comb
    begin
        cmd.iw     = glyph_width - lr_sum[gbr_pkg::DIM_BITS-1:0];
        cmd.ih     = glyph_height - tb_sum[gbr_pkg::DIM_BITS-1:0];
        cmd.lead   = lead_sum[gbr_pkg::RUN_BITS-1:0];
        cmd.gap    = gbr_pkg::RUN_BITS'(lr_sum);
        cmd.trail  = trail_sum[gbr_pkg::RUN_BITS-1:0];
        cmd.pixels = bitmap_byte;
        priority if (op)
        begin
            cmd.kind = gbr_pkg::CMD_DATA;
        end
        else if (zero_dim)
        begin
            cmd.kind = gbr_pkg::CMD_NONE;
        end
        else if (no_interior)
        begin
            cmd.kind  = gbr_pkg::CMD_BLANK;
            cmd.trail = area_prod[gbr_pkg::RUN_BITS-1:0];
        end
        else
        begin
            cmd.kind = gbr_pkg::CMD_GLYPH;
        end
    end

endmodule

>>> rtl/gbr_cmd_queue.sv
// Short command queue between the front end and the run sequencer.
module gbr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbr_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output gbr_pkg::cmd_t rdata,
    output logic          empty
);

    gbr_pkg::cmd_t                  slot_reg [gbr_pkg::Q_DEPTH];
    logic [gbr_pkg::Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [gbr_pkg::Q_PTR_BITS-1:0] wr_ptr_next;
    logic [gbr_pkg::Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [gbr_pkg::Q_PTR_BITS-1:0] rd_ptr_next;
    logic [gbr_pkg::Q_CNT_BITS-1:0] count_reg;
    logic [gbr_pkg::Q_CNT_BITS-1:0] count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == gbr_pkg::Q_CNT_BITS'(gbr_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gbr_pkg::Q_CNT_BITS'(gbr_pkg::Q_DEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == gbr_pkg::Q_PTR_BITS'(rd_ptr_reg + count_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/gbr_back.sv
// Back end: walk commands and emit one color run per cycle into out_reg unless stalled.
module gbr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  gbr_pkg::cmd_t    cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  gbr_pkg::colors_t colors,
    output gbr_pkg::run_t    run,
    output logic             run_valid,
    input  logic             run_pop
);

    typedef enum logic [1:0] {
        PH_PIXEL = 2'b01,
        PH_TRAIL = 2'b10
    } phase_t;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic                            active_reg;
    logic                            active_next;
    logic                            pre_done_reg;
    logic                            pre_done_next;
    logic [gbr_pkg::K_BITS-1:0]      k_reg;
    logic [gbr_pkg::K_BITS-1:0]      k_next;
    logic [gbr_pkg::DIM_BITS-1:0]    row_reg;
    logic [gbr_pkg::DIM_BITS-1:0]    row_next;
    logic [gbr_pkg::DIM_BITS-1:0]    col_reg;
    logic [gbr_pkg::DIM_BITS-1:0]    col_next;
    logic [gbr_pkg::DIM_BITS-1:0]    iw_reg;
    logic [gbr_pkg::DIM_BITS-1:0]    iw_next;
    logic [gbr_pkg::DIM_BITS-1:0]    ih_reg;
    logic [gbr_pkg::DIM_BITS-1:0]    ih_next;
    logic [gbr_pkg::RUN_BITS-1:0]    lead_reg;
    logic [gbr_pkg::RUN_BITS-1:0]    lead_next;
    logic [gbr_pkg::RUN_BITS-1:0]    gap_reg;
    logic [gbr_pkg::RUN_BITS-1:0]    gap_next;
    logic [gbr_pkg::RUN_BITS-1:0]    trail_reg;
    logic [gbr_pkg::RUN_BITS-1:0]    trail_next;
    gbr_pkg::run_t                   out_reg;
    gbr_pkg::run_t                   out_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic                            out_ready;
    logic                            emit;
    logic [gbr_pkg::RUN_BITS-1:0]    pre_len;
    logic [gbr_pkg::PIX_BITS-1:0]    pix;
    logic [gbr_pkg::DIM_BITS:0]      col_inc;
    logic [gbr_pkg::DIM_BITS:0]      row_inc;
    logic                            col_wrap;
    logic                            finish;

    assign out_ready = !out_valid_reg || run_pop;
    assign pre_len   = (row_reg == '0) ? lead_reg : gap_reg;
    assign pix       = gbr_pkg::PIX_BITS'(cmd.pixels >> {k_reg, 1'b0});
    assign col_inc   = {1'b0, col_reg} + (gbr_pkg::DIM_BITS + 1)'(1);
    assign row_inc   = {1'b0, row_reg} + (gbr_pkg::DIM_BITS + 1)'(1);
    assign col_wrap  = (col_inc >= {1'b0, iw_reg});
    assign finish    = col_wrap && (row_inc >= {1'b0, ih_reg});

    always_comb
    begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        pre_done_next = pre_done_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        iw_next       = iw_reg;
        ih_next       = ih_reg;
        lead_next     = lead_reg;
        gap_next      = gap_reg;
        trail_next    = trail_reg;
        cmd_pop       = 1'b0;
        emit          = 1'b0;
        out_next      = out_reg;

        if (cmd_valid && out_ready)
        begin
            unique case (cmd.kind)
                gbr_pkg::CMD_NONE:
                begin
                    active_next   = 1'b0;
                    row_next      = '0;
                    col_next      = '0;
                    k_next        = '0;
                    pre_done_next = 1'b0;
                    phase_next    = PH_PIXEL;
                    cmd_pop       = 1'b1;
                end
                gbr_pkg::CMD_GLYPH:
                begin
                    active_next   = 1'b1;
                    row_next      = '0;
                    col_next      = '0;
                    k_next        = '0;
                    pre_done_next = 1'b0;
                    phase_next    = PH_PIXEL;
                    iw_next       = cmd.iw;
                    ih_next       = cmd.ih;
                    lead_next     = cmd.lead;
                    gap_next      = cmd.gap;
                    trail_next    = cmd.trail;
                    cmd_pop       = 1'b1;
                end
                gbr_pkg::CMD_BLANK:
                begin
                    active_next     = 1'b0;
                    row_next        = '0;
                    col_next        = '0;
                    k_next          = '0;
                    pre_done_next   = 1'b0;
                    phase_next      = PH_PIXEL;
                    emit            = 1'b1;
                    out_next.color  = colors.background;
                    out_next.length = cmd.trail;
                    out_next.last   = 1'b1;
                    out_next.done   = 1'b1;
                    cmd_pop         = 1'b1;
                end
                gbr_pkg::CMD_DATA:
                begin
                    if (!active_reg && (phase_reg != PH_TRAIL))
                    begin
                        cmd_pop = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_PIXEL:
                            begin
                                emit = 1'b1;
                                if ((col_reg == '0) && !pre_done_reg && (pre_len != '0))
                                begin
                                    out_next.color  = colors.background;
                                    out_next.length = pre_len;
                                    out_next.last   = 1'b0;
                                    out_next.done   = 1'b0;
                                    pre_done_next   = 1'b1;
                                end
                                else
                                begin
                                    out_next.color  = gbr_pkg::level_color(pix, colors);
                                    out_next.length = gbr_pkg::RUN_BITS'(1);
                                    out_next.last   = 1'b0;
                                    out_next.done   = 1'b0;
                                    pre_done_next   = 1'b0;
                                    if (finish)
                                    begin
                                        active_next = 1'b0;
                                        row_next    = '0;
                                        col_next    = '0;
                                        if (trail_reg != '0)
                                        begin
                                            phase_next = PH_TRAIL;
                                        end
                                        else
                                        begin
                                            out_next.last = 1'b1;
                                            out_next.done = 1'b1;
                                            k_next        = '0;
                                            cmd_pop       = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        col_next = col_wrap ? '0
                                                            : col_inc[gbr_pkg::DIM_BITS-1:0];
                                        row_next = col_wrap ? row_inc[gbr_pkg::DIM_BITS-1:0]
                                                            : row_reg;
                                        if (k_reg == gbr_pkg::K_LAST)
                                        begin
                                            out_next.last = 1'b1;
                                            k_next        = '0;
                                            cmd_pop       = 1'b1;
                                        end
                                        else
                                        begin
                                            k_next = k_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            PH_TRAIL:
                            begin
                                emit            = 1'b1;
                                out_next.color  = colors.background;
                                out_next.length = trail_reg;
                                out_next.last   = 1'b1;
                                out_next.done   = 1'b1;
                                phase_next      = PH_PIXEL;
                                k_next          = '0;
                                cmd_pop         = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_PIXEL;
                            end
                        endcase
                    end
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (run_pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg    <= iw_next;
        ih_reg    <= ih_next;
        lead_reg  <= lead_next;
        gap_reg   <= gap_next;
        trail_reg <= trail_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PIXEL;
            active_reg    <= 1'b0;
            pre_done_reg  <= 1'b0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            pre_done_reg  <= pre_done_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign run       = out_reg;
    assign run_valid = out_valid_reg;

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.length != '0))
        else $error("run of zero length on output");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done) |-> out_reg.last)
        else $error("glyph end not on last run of beat");

    a_trail_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRAIL) |-> !active_reg)
        else $error("trailing run pending while glyph still active");

    a_pre_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
        pre_done_reg |-> (col_reg == '0))
        else $error("border run taken away from row start");

endmodule

>>> rtl/glyph_2bpp_bbox_renderer.sv
// Top level: color registers, front end, command queue and run sequencer.
// The first run of a beat passes through a queue slot and then the output register.
// Throughput: a header or a byte with no glyph yields at most one run; a data byte yields
// one or more runs, one per cycle unless output stalls, set by the single back-end sequencer.
// Reset: queue pointers, glyph state and output valid flag clear at once; colors return
// to their reset values; no clearing pass, the block takes beats right after.
module glyph_2bpp_bbox_renderer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              op,
    input  logic [gbr_pkg::DIM_BITS-1:0]      glyph_width,
    input  logic [gbr_pkg::DIM_BITS-1:0]      glyph_height,
    input  logic [gbr_pkg::DIM_BITS-1:0]      top_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]      bottom_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]      left_margin,
    input  logic [gbr_pkg::DIM_BITS-1:0]      right_margin,
    input  logic [gbr_pkg::BYTE_BITS-1:0]     bitmap_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [gbr_pkg::COLOR_BITS-1:0]    pixel_color,
    output logic [gbr_pkg::RUN_BITS-1:0]      run_length,
    output logic                              last_of_item,
    output logic                              glyph_done,
    input  logic                              cfg_we,
    input  logic [gbr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gbr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    gbr_pkg::colors_t colors_reg;
    gbr_pkg::colors_t colors_next;
    gbr_pkg::cmd_t    front_cmd;
    gbr_pkg::cmd_t    head_cmd;
    gbr_pkg::run_t    out_run;
    logic             q_empty;
    logic             q_pop;
    logic             run_valid;

    always_comb
    begin
        colors_next = colors_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gbr_pkg::REG_BACKGROUND:
                    colors_next.background = gbr_pkg::COLOR_BITS'(cfg_data);
                gbr_pkg::REG_BRUSH_FULL:
                    colors_next.full = gbr_pkg::COLOR_BITS'(cfg_data);
                gbr_pkg::REG_BRUSH_2THRD:
                    colors_next.two_thirds = gbr_pkg::COLOR_BITS'(cfg_data);
                gbr_pkg::REG_BRUSH_1THRD:
                    colors_next.one_third = gbr_pkg::COLOR_BITS'(cfg_data);
                default:
                    colors_next = colors_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg.background <= '0;
            colors_reg.full       <= gbr_pkg::FULL_COLOR_RESET;
            colors_reg.two_thirds <= '0;
            colors_reg.one_third  <= '0;
        end
        else
        begin
            colors_reg <= colors_next;
        end
    end

    gbr_front u_front (
        .op            (op),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .top_margin    (top_margin),
        .bottom_margin (bottom_margin),
        .left_margin   (left_margin),
        .right_margin  (right_margin),
        .bitmap_byte   (bitmap_byte),
        .cmd           (front_cmd)
    );

    gbr_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (q_pop),
        .rdata (head_cmd),
        .empty (q_empty)
    );

    gbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .colors    (colors_reg),
        .run       (out_run),
        .run_valid (run_valid),
        .run_pop   (pop)
    );

    assign empty        = !run_valid;
    assign pixel_color  = out_run.color;
    assign run_length   = out_run.length;
    assign last_of_item = out_run.last;
    assign glyph_done   = out_run.done;

endmodule
